// ===== rtl/fts_pkg.sv =====
// Shared constants, codes and types for the fault-tolerant stack.
package fts_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int DATA_W  = 32;
    localparam int SKIP_W  = 7;
    localparam int COUNT_W = 9;
    localparam int POS_W   = 8;
    localparam int CMD_W   = 2;
    localparam int NCNT_W  = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DATA_W-1:0] INVERT_ALL   = 32'hFFFF_FFFF;
    localparam logic [SKIP_W-1:0] SKIP_RESET   = 7'd3;
    localparam logic [DATA_W-1:0] MARKER_RESET = 32'hDEAD_BEEF;

    // Register index is paddr[2]
    localparam logic REG_SKIP   = 1'b0;
    localparam logic REG_MARKER = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_INJECT = 2'd3
    } fts_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_CHECK,
        ST_INJ_RD,
        ST_INJ_WR
    } fts_state_t;

    typedef struct packed {
        logic [DATA_W-1:0]        marker;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] copy;
    } fts_cell_t;

    typedef struct packed {
        logic [SKIP_W-1:0] skip_limit;
        logic [DATA_W-1:0] marker_word;
    } fts_cfg_t;

    typedef struct packed {
        logic load;       // latch item, start scan at top
        logic push;       // write full cell at top, raise top
        logic scan_rd;    // read cell below scan pointer, step down
        logic inj_rd;     // read cell at position
        logic inj_wr;     // write back cell with inverted marker
        logic fin;        // issue result
        logic fin_ok;
        logic fin_value;  // result carries value of last read cell
        logic fin_pop;    // top takes scan pointer
    } fts_cmd_t;

    typedef struct packed {
        logic full;
        logic scan_end;
        logic cell_good;
        logic pos_ok;
    } fts_stat_t;

endpackage

// ===== rtl/fts_regs.sv =====
// APB configuration registers: skip limit and marker word.
module fts_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fts_pkg::PADDR_W-1:0]  paddr,
    input  logic [fts_pkg::PDATA_W-1:0]  pwdata,
    output logic [fts_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output fts_pkg::fts_cfg_t            cfg
);

    logic [fts_pkg::SKIP_W-1:0] skip_reg;
    logic [fts_pkg::DATA_W-1:0] marker_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg   <= fts_pkg::SKIP_RESET;
            marker_reg <= fts_pkg::MARKER_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == fts_pkg::REG_SKIP)
            begin
                skip_reg <= pwdata[fts_pkg::SKIP_W-1:0];
            end
            else
            begin
                marker_reg <= pwdata[fts_pkg::DATA_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == fts_pkg::REG_MARKER)
        begin
            prdata = marker_reg;
        end
        else
        begin
            prdata = {{(fts_pkg::PDATA_W - fts_pkg::SKIP_W){1'b0}}, skip_reg};
        end
    end

    assign cfg.skip_limit  = skip_reg;
    assign cfg.marker_word = marker_reg;

endmodule

// ===== rtl/fts_datapath.sv =====
// Datapath: cell memory, top and scan pointers, result registers.
module fts_datapath #(
    parameter int DEPTH = fts_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fts_pkg::fts_cfg_t                   cfg,
    input  fts_pkg::fts_cmd_t                   ctl,
    output fts_pkg::fts_stat_t                  stat,
    input  logic signed [fts_pkg::DATA_W-1:0]   push_value,
    input  logic [fts_pkg::POS_W-1:0]           position,
    output logic                                done,
    output logic                                ok,
    output logic signed [fts_pkg::DATA_W-1:0]   read_value,
    output logic [fts_pkg::COUNT_W-1:0]         count
);

    localparam int AW = $clog2(DEPTH);
    localparam int TW = $clog2(DEPTH + 1);

    fts_pkg::fts_cell_t mem [DEPTH];
    fts_pkg::fts_cell_t rdata_reg;
    fts_pkg::fts_cell_t wdata;

    logic [TW-1:0]                  top_reg, top_next;
    logic [TW-1:0]                  p_reg;
    logic [TW-1:0]                  p_dec;
    logic [fts_pkg::NCNT_W-1:0]     n_reg;
    logic signed [fts_pkg::DATA_W-1:0] value_reg;
    logic [fts_pkg::POS_W-1:0]      position_reg;
    logic [AW-1:0]                  pos_addr;
    logic [AW-1:0]                  waddr, raddr;
    logic                           wen, ren;
    logic [31:0]                    top_wide;

    logic                               done_reg;
    logic                               ok_reg;
    logic signed [fts_pkg::DATA_W-1:0]  read_value_reg;
    logic [fts_pkg::COUNT_W-1:0]        count_reg;

    assign p_dec    = p_reg - TW'(1);
    assign pos_addr = AW'(position_reg);

    assign stat.full      = (top_reg == TW'(DEPTH));
    assign stat.scan_end  = (p_reg == '0)
                            || (n_reg > fts_pkg::NCNT_W'(cfg.skip_limit));
    assign stat.cell_good = (rdata_reg.marker == cfg.marker_word)
                            && (rdata_reg.value == rdata_reg.copy);
    assign stat.pos_ok    = (32'(position_reg) < 32'(DEPTH));

    // One write port and one read port into the cell memory
    always_comb
    begin
        wen   = ctl.push || ctl.inj_wr;
        ren   = ctl.scan_rd || ctl.inj_rd;
        waddr = ctl.push ? top_reg[AW-1:0] : pos_addr;
        raddr = ctl.scan_rd ? p_dec[AW-1:0] : pos_addr;
        if (ctl.push)
        begin
            wdata.marker = cfg.marker_word;
            wdata.value  = value_reg;
            wdata.copy   = value_reg;
        end
        else
        begin
            wdata.marker = rdata_reg.marker ^ fts_pkg::INVERT_ALL;
            wdata.value  = rdata_reg.value;
            wdata.copy   = rdata_reg.copy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        top_next = top_reg;
        if (ctl.push)
        begin
            top_next = top_reg + TW'(1);
        end
        else if (ctl.fin && ctl.fin_pop)
        begin
            top_next = p_reg;
        end
    end

    assign top_wide = 32'(top_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            top_reg  <= top_next;
            done_reg <= ctl.fin;
        end
    end

    // Item payload, scan state and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            value_reg    <= push_value;
            position_reg <= position;
            p_reg        <= top_reg;
            n_reg        <= '0;
        end
        else if (ctl.scan_rd)
        begin
            p_reg <= p_dec;
            n_reg <= n_reg + fts_pkg::NCNT_W'(1);
        end
        if (ctl.fin)
        begin
            ok_reg         <= ctl.fin_ok;
            read_value_reg <= ctl.fin_value ? rdata_reg.value : '0;
            count_reg      <= top_wide[fts_pkg::COUNT_W-1:0];
        end
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;

endmodule

// ===== rtl/fts_ctrl.sv =====
// Controller: sequences push, scan and fault injection.
module fts_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fts_pkg::CMD_W-1:0]   cmd,
    input  fts_pkg::fts_stat_t          stat,
    output fts_pkg::fts_cmd_t           ctl,
    output logic                        busy
);

    fts_pkg::fts_state_t state_reg, state_next;
    fts_pkg::fts_op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fts_pkg::ST_IDLE;
            op_reg    <= fts_pkg::OP_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ctl        = '0;
        case (state_reg)
            fts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    op_next  = fts_pkg::fts_op_t'(cmd);
                    case (fts_pkg::fts_op_t'(cmd))
                        fts_pkg::OP_PUSH:   state_next = fts_pkg::ST_PUSH;
                        fts_pkg::OP_POP:    state_next = fts_pkg::ST_SCAN;
                        fts_pkg::OP_PEEK:   state_next = fts_pkg::ST_SCAN;
                        fts_pkg::OP_INJECT: state_next = fts_pkg::ST_INJ_RD;
                        default:            state_next = fts_pkg::ST_IDLE;
                    endcase
                end
            end
            fts_pkg::ST_PUSH:
            begin
                ctl.push   = !stat.full;
                ctl.fin    = 1'b1;
                ctl.fin_ok = !stat.full;
                state_next = fts_pkg::ST_IDLE;
            end
            fts_pkg::ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    // nothing valid within reach: pop keeps the lowered top
                    ctl.fin     = 1'b1;
                    ctl.fin_pop = (op_reg == fts_pkg::OP_POP);
                    state_next  = fts_pkg::ST_IDLE;
                end
                else
                begin
                    ctl.scan_rd = 1'b1;
                    state_next  = fts_pkg::ST_CHECK;
                end
            end
            fts_pkg::ST_CHECK:
            begin
                if (stat.cell_good)
                begin
                    ctl.fin       = 1'b1;
                    ctl.fin_ok    = 1'b1;
                    ctl.fin_value = 1'b1;
                    ctl.fin_pop   = (op_reg == fts_pkg::OP_POP);
                    state_next    = fts_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fts_pkg::ST_SCAN;
                end
            end
            fts_pkg::ST_INJ_RD:
            begin
                if (stat.pos_ok)
                begin
                    ctl.inj_rd = 1'b1;
                    state_next = fts_pkg::ST_INJ_WR;
                end
                else
                begin
                    ctl.fin    = 1'b1;
                    state_next = fts_pkg::ST_IDLE;
                end
            end
            fts_pkg::ST_INJ_WR:
            begin
                ctl.inj_wr = 1'b1;
                ctl.fin    = 1'b1;
                ctl.fin_ok = 1'b1;
                state_next = fts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fts_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != fts_pkg::ST_IDLE);

endmodule

// ===== rtl/fault_tolerant_stack_core.sv =====
// Fault-tolerant stack: top level joining registers, controller and datapath.
// Pop and peek examine up to skip_limit+1 cells, each with one read of the cell memory
// and one check.
// One item at a time: busy stays high until the result shows; the next item is taken
// in the cycle done is high. Results cannot be stalled by the receiver.
// Reset: controller idle, top pointer zero, registers to reset values, cells not cleared.
module fault_tolerant_stack_core #(
    parameter int DEPTH = fts_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fts_pkg::CMD_W-1:0]           cmd,
    input  logic signed [fts_pkg::DATA_W-1:0]   push_value,
    input  logic [fts_pkg::POS_W-1:0]           position,
    output logic                                done,
    output logic                                ok,
    output logic signed [fts_pkg::DATA_W-1:0]   read_value,
    output logic [fts_pkg::COUNT_W-1:0]         count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fts_pkg::PADDR_W-1:0]         paddr,
    input  logic [fts_pkg::PDATA_W-1:0]         pwdata,
    output logic [fts_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    fts_pkg::fts_cfg_t  cfg;
    fts_pkg::fts_cmd_t  ctl;
    fts_pkg::fts_stat_t stat;

    fts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    fts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .ctl        (ctl),
        .stat       (stat),
        .push_value (push_value),
        .position   (position),
        .done       (done),
        .ok         (ok),
        .read_value (read_value),
        .count      (count)
    );

endmodule

// ===== rtl/fts_checker.sv =====
// Port-level checker for the fault-tolerant stack, bound to the top level.
module fts_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic                               ok,
    input logic signed [fts_pkg::DATA_W-1:0]  read_value
);

    // an accepted item keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // a result is shown only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a failed operation returns no value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_value == '0))
        else $error("failed operation returned a value");

endmodule

bind fault_tolerant_stack_core fts_checker u_fts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .ok         (ok),
    .read_value (read_value)
);

// ===== tb/fault_tolerant_stack_core_test.sv =====
// Self-checking testbench for the fault-tolerant stack core.
`timescale 1ns / 1ps

module fault_tolerant_stack_core_test;

    import fts_pkg::*;

    localparam int          STACK_DEPTH = DEPTH_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    // Tail wait sized for the longest scan: skip limit 127, 128 cells, plus slack
    localparam int          TAIL_CYCLES = 2 * 128 + 16;

    localparam logic [PADDR_W-1:0] SKIP_ADDR   = {REG_SKIP, 2'b00};
    localparam logic [PADDR_W-1:0] MARKER_ADDR = {REG_MARKER, 2'b00};

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       depth;
    } stack_reply_t;

    logic                       clk;
    logic                       rst_n      = 1'b0;
    logic                       start      = 1'b0;
    logic                       busy;
    logic [CMD_W-1:0]           cmd        = OP_PUSH;
    logic signed [DATA_W-1:0]   push_value = '0;
    logic [POS_W-1:0]           position   = '0;
    logic                       done;
    logic                       ok;
    logic signed [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]         count;
    logic                       psel       = 1'b0;
    logic                       penable    = 1'b0;
    logic                       pwrite     = 1'b0;
    logic [PADDR_W-1:0]         paddr      = '0;
    logic [PDATA_W-1:0]         pwdata     = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // Shadow copy of the stack
    logic [DATA_W-1:0]          shadow_marker [STACK_DEPTH];
    logic signed [DATA_W-1:0]   shadow_value  [STACK_DEPTH];
    logic signed [DATA_W-1:0]   shadow_copy   [STACK_DEPTH];
    logic [COUNT_W-1:0]         stack_top     = '0;
    int unsigned                cells_written = 0;
    logic [SKIP_W-1:0]          skip_cfg      = SKIP_RESET;
    logic [DATA_W-1:0]          marker_cfg    = MARKER_RESET;

    stack_reply_t               pending_replies[$];
    int unsigned                mismatches    = 0;
    bit                         idle_gaps     = 1'b1;

    fault_tolerant_stack_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .push_value (push_value),
        .position   (position),
        .done       (done),
        .ok         (ok),
        .read_value (read_value),
        .count      (count),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("fault_tolerant_stack_core_test NOT OK");
        $finish;
    end

    // Work out the reply of one accepted item and advance the shadow stack
    task automatic apply_stack_op(fts_op_t op, logic signed [DATA_W-1:0] val,
                                  logic [POS_W-1:0] pos);
        stack_reply_t reply;
        int unsigned  scan_pos;
        int unsigned  seen;
        bit           hit;
        reply = '0;
        case (op)
            OP_PUSH:
            begin
                if (stack_top < STACK_DEPTH)
                begin
                    shadow_marker[stack_top[POS_W-1:0]] = marker_cfg;
                    shadow_value[stack_top[POS_W-1:0]]  = val;
                    shadow_copy[stack_top[POS_W-1:0]]   = val;
                    stack_top = stack_top + 1'b1;
                    if (stack_top > cells_written)
                        cells_written = stack_top;
                    reply.ok = 1'b1;
                end
            end
            OP_POP, OP_PEEK:
            begin
                scan_pos = stack_top;
                seen     = 0;
                hit      = 1'b0;
                while (!hit && scan_pos > 0 && seen <= skip_cfg)
                begin
                    scan_pos--;
                    seen++;
                    if (shadow_marker[POS_W'(scan_pos)] == marker_cfg &&
                        shadow_value[POS_W'(scan_pos)] == shadow_copy[POS_W'(scan_pos)])
                    begin
                        hit         = 1'b1;
                        reply.ok    = 1'b1;
                        reply.value = shadow_value[POS_W'(scan_pos)];
                    end
                end
                // pop keeps the pointer lowered past every cell it examined
                if (op == OP_POP)
                    stack_top = COUNT_W'(stack_top - seen);
            end
            default:
            begin
                if (pos < STACK_DEPTH)
                begin
                    shadow_marker[pos] = shadow_marker[pos] ^ INVERT_ALL;
                    reply.ok = 1'b1;
                end
            end
        endcase
        reply.depth = stack_top;
        pending_replies.push_back(reply);
    endtask

    task automatic send_op(fts_op_t op, logic signed [DATA_W-1:0] val,
                           logic [POS_W-1:0] pos);
        int gap;
        if (idle_gaps && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        push_value <= val;
        position   <= pos;
        do
            @(posedge clk);
        while (busy);
        apply_stack_op(op, val, pos);
    endtask

    // Hold off until every reply is in and the core has gone quiet
    task automatic wait_for_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        bit bad;
        wait_for_replies();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == SKIP_ADDR)
            skip_cfg = data[SKIP_W-1:0];
        else
            marker_cfg = data;
        // read back in a second transfer, psel held
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == SKIP_ADDR)
            bad = prdata[SKIP_W-1:0] != skip_cfg;
        else
            bad = prdata != marker_cfg;
        if (bad)
        begin
            $display("%0t: register %0d read expected %h actual %h", $time, addr,
                     (addr == SKIP_ADDR) ? {25'b0, skip_cfg} : marker_cfg, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic issue_random_op();
        fts_op_t                  op;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         pos;
        int unsigned              roll;
        int unsigned              push_pct;
        int unsigned              reach;
        roll     = $urandom_range(0, 99);
        push_pct = (stack_top < 32) ? 50 : (stack_top > 224) ? 25 : 38;
        val      = $urandom;
        pos      = POS_W'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7FFF_FFFF;
                2: val = '0;
                default: val = '1;
            endcase
        end
        if (roll < push_pct)
            op = OP_PUSH;
        else if (roll < push_pct + 25)
            op = OP_POP;
        else if (roll < push_pct + 45)
            op = OP_PEEK;
        else
            op = OP_INJECT;
        if (op == OP_INJECT)
        begin
            // only cells already written may be touched
            if (cells_written == 0)
                op = OP_PUSH;
            else if (stack_top > 0 && $urandom_range(0, 3) != 0)
            begin
                reach = (stack_top - 1 < skip_cfg + 1) ? stack_top - 1 : skip_cfg + 1;
                pos   = POS_W'(stack_top - 1 - $urandom_range(0, reach));
            end
            else
                pos = POS_W'($urandom_range(0, cells_written - 1));
        end
        send_op(op, val, pos);
    endtask

    always @(posedge clk)
    begin : check_replies
        stack_reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with nothing expected: ok %0d value %0d count %0d",
                         $time, ok, read_value, count);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (ok !== want.ok)
                begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, ok);
                    mismatches++;
                end
                if (read_value !== want.value)
                begin
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             want.value, read_value);
                    mismatches++;
                end
                if (count !== want.depth)
                begin
                    $display("%0t: count expected %0d actual %0d", $time,
                             want.depth, count);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_op(OP_POP, '0, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_PUSH, 32'sh8000_0000, 8'hFF);
        send_op(OP_PUSH, 32'sh7FFF_FFFF, 8'h00);
        send_op(OP_PUSH, '0, 8'hAA);
        send_op(OP_PUSH, '1, 8'h55);
        send_op(OP_PUSH, 32'sh5555_5555, '0);
        send_op(OP_PUSH, 32'shAAAA_AAAA, '0);
        send_op(OP_PEEK, '0, '0);
        // corrupt the top cell, then repair it by inverting again
        send_op(OP_INJECT, '0, 8'd5);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_INJECT, '1, 8'd5);
        send_op(OP_PEEK, '0, '0);
        // more bad cells than the scan may skip: pop fails, pointer drops
        send_op(OP_INJECT, '0, 8'd5);
        send_op(OP_INJECT, '0, 8'd4);
        send_op(OP_INJECT, '0, 8'd3);
        send_op(OP_INJECT, '0, 8'd2);
        send_op(OP_POP, '0, '0);
        send_op(OP_POP, '0, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_POP, '0, '0);
        send_op(OP_POP, '0, '0);
    endtask

    task automatic test_skip_limits();
        logic [SKIP_W-1:0] limits [5];
        limits = '{7'd0, 7'd1, 7'd127, 7'd64, SKIP_RESET};
        foreach (limits[i])
        begin
            write_reg(SKIP_ADDR, {25'($urandom_range(0, 33554431)), limits[i]});
            repeat (150) issue_random_op();
        end
    endtask

    task automatic test_marker_words();
        logic [DATA_W-1:0] words [4];
        words = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, MARKER_RESET};
        foreach (words[i])
        begin
            write_reg(MARKER_ADDR, words[i]);
            repeat (60) issue_random_op();
        end
    endtask

    task automatic test_full_stack();
        while (stack_top < STACK_DEPTH)
            send_op(OP_PUSH, $urandom, POS_W'($urandom));
        send_op(OP_PUSH, 32'sh1234_5678, '0);
        send_op(OP_INJECT, '0, 8'd255);
        send_op(OP_INJECT, '0, 8'd128);
        send_op(OP_INJECT, '0, 8'd200);
        send_op(OP_PEEK, '0, '0);
        repeat (3) send_op(OP_POP, '0, '0);
        repeat (100) issue_random_op();
    endtask

    task automatic test_random_mix();
        idle_gaps = 1'b0;
        repeat (120) issue_random_op();
        idle_gaps = 1'b1;
        repeat (80) issue_random_op();
        wait_for_replies();
        repeat (150) issue_random_op();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_skip_limits();
        test_marker_words();
        test_full_stack();
        test_random_mix();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("fault_tolerant_stack_core_test OK");
        else
            $display("fault_tolerant_stack_core_test NOT OK");
        $finish;
    end

endmodule
